// ----- sv/shvw_pkg.sv -----
// ---------------------------------------------------------------------------
// shvw_pkg
// Shared constants, register indices, state and memory request types for the
// spatial hash vertex weld.
// ---------------------------------------------------------------------------
package shvw_pkg;

  localparam int TABLE_SIZE   = 1024;
  localparam int BUCKET_DEPTH = 8;
  localparam int BUCKET_W     = $clog2(TABLE_SIZE);
  localparam int SLOT_W       = $clog2(BUCKET_DEPTH);
  localparam int ID_W         = 13;
  localparam int ADDR_W       = BUCKET_W + SLOT_W;
  localparam int FILL_W       = $clog2(BUCKET_DEPTH + 1);
  localparam int COORD_W      = 32;
  localparam int CSIZE_W      = 31;
  localparam int CFG_IDX_W    = 3;

  localparam logic [CSIZE_W-1:0] CELL_SIZE_RST = 31'd65536;
  localparam logic [CSIZE_W-1:0] TOL_RST       = 31'd66;
  localparam logic [31:0]        PRIME_X_RST   = 32'd73856093;
  localparam logic [31:0]        PRIME_Y_RST   = 32'd19349663;
  localparam logic [31:0]        PRIME_Z_RST   = 32'd83492791;

  localparam logic [FILL_W-1:0]  FILL_MAX = FILL_W'(BUCKET_DEPTH);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CELL_SIZE = 3'd0,
    REG_TOLERANCE = 3'd1,
    REG_PRIME_X   = 3'd2,
    REG_PRIME_Y   = 3'd3,
    REG_PRIME_Z   = 3'd4
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_SUM,
    ST_FRD,
    ST_FWAIT,
    ST_PRD,
    ST_CMP,
    ST_WR
  } state_t;

  typedef struct packed {
    logic                  pt_we;
    logic [ADDR_W-1:0]     pt_addr;
    logic [3*COORD_W-1:0]  pt_wdata;
    logic                  fill_we;
    logic [BUCKET_W-1:0]   fill_addr;
    logic [FILL_W-1:0]     fill_wdata;
  } mem_req_t;

endpackage

// ----- sv/shvw_div.sv -----
// ---------------------------------------------------------------------------
// shvw_div
// Restoring radix-2 divider: 32-bit magnitude by 31-bit cell size, one
// quotient bit per cycle. A zero divisor acts as one.
// ---------------------------------------------------------------------------
module shvw_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [30:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);
  import shvw_pkg::*;

  logic        run_r, run_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [30:0] rem_r, rem_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [30:0] dvs_r, dvs_nxt;
  logic        done_r, done_nxt;
  logic [31:0] rem_sh;
  logic        ge;

  assign rem_sh = {rem_r, quo_r[31]};
  assign ge     = rem_sh >= {1'b0, dvs_r};

  always_comb begin
    run_nxt  = run_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    done_nxt = 1'b0;
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = '0;
      rem_nxt = '0;
      quo_nxt = dividend;
      dvs_nxt = (divisor == '0) ? 31'd1 : divisor;
    end else if (run_r) begin
      rem_nxt = ge ? 31'(rem_sh - {1'b0, dvs_r}) : rem_sh[30:0];
      quo_nxt = {quo_r[30:0], ge};
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ----- sv/shvw_store.sv -----
// ---------------------------------------------------------------------------
// shvw_store
// Point memory and bucket fill memory, both with registered reads. Sweeps
// the fill memory to zero after reset.
// ---------------------------------------------------------------------------
module shvw_store (
  input  logic                               clk,
  input  logic                               rst_n,
  input  shvw_pkg::mem_req_t                 req,
  output logic [3*shvw_pkg::COORD_W-1:0]     pt_rdata,
  output logic [shvw_pkg::FILL_W-1:0]        fill_rdata,
  output logic                               init_done
);
  import shvw_pkg::*;

  logic [3*COORD_W-1:0] pt_mem   [TABLE_SIZE*BUCKET_DEPTH];
  logic [FILL_W-1:0]    fill_mem [TABLE_SIZE];

  logic [BUCKET_W:0]   clr_r, clr_nxt;
  logic                clearing;
  logic                fwe;
  logic [BUCKET_W-1:0] faddr;
  logic [FILL_W-1:0]   fdata;
  logic [3*COORD_W-1:0] pt_q_r;
  logic [FILL_W-1:0]    fill_q_r;

  assign clearing = !clr_r[BUCKET_W];
  assign clr_nxt  = clearing ? clr_r + 1'b1 : clr_r;
  assign fwe      = clearing | req.fill_we;
  assign faddr    = clearing ? clr_r[BUCKET_W-1:0] : req.fill_addr;
  assign fdata    = clearing ? '0 : req.fill_wdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else begin
      clr_r <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req.pt_we) begin
      pt_mem[req.pt_addr] <= req.pt_wdata;
    end
    pt_q_r <= pt_mem[req.pt_addr];
  end

  always_ff @(posedge clk) begin
    if (fwe) begin
      fill_mem[faddr] <= fdata;
    end
    fill_q_r <= fill_mem[req.fill_addr];
  end

  assign pt_rdata   = pt_q_r;
  assign fill_rdata = fill_q_r;
  assign init_done  = !clearing;

endmodule

// ----- sv/spatial_hash_vertex_weld.sv -----
// ---------------------------------------------------------------------------
// spatial_hash_vertex_weld
// Each item passes the cell-index dividers, the hash (products, then the
// bucket), the fill read, then a read and a compare per bucket slot scanned
// (S = 0..8 slots, ending early on a match), and the write state when no
// slot matches. Throughput: one item at a time; the next item can be
// accepted while the result strobe is high.
// After reset the fill memory is swept to zero; busy stays high meanwhile.
// The result strobe lasts one cycle and cannot be stalled.
// ---------------------------------------------------------------------------
module spatial_hash_vertex_weld (
  input  logic                            clk,
  input  logic                            rst_n,
  // item input
  input  logic                            start,
  output logic                            busy,
  input  logic signed [31:0]              in_pos_x,
  input  logic signed [31:0]              in_pos_y,
  input  logic signed [31:0]              in_pos_z,
  // result output
  output logic                            out_valid,
  output logic [shvw_pkg::ID_W-1:0]       out_entry_id,
  output logic                            out_matched,
  output logic                            out_bucket_full,
  // configuration write
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [shvw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                     cfg_data
);
  import shvw_pkg::*;

  // Configuration registers
  logic [CSIZE_W-1:0] cell_size_r;
  logic [CSIZE_W-1:0] tol_r;
  logic [31:0]        prime_x_r, prime_y_r, prime_z_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_size_r <= CELL_SIZE_RST;
      tol_r       <= TOL_RST;
      prime_x_r   <= PRIME_X_RST;
      prime_y_r   <= PRIME_Y_RST;
      prime_z_r   <= PRIME_Z_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_CELL_SIZE: cell_size_r <= cfg_data[CSIZE_W-1:0];
        REG_TOLERANCE: tol_r       <= cfg_data[CSIZE_W-1:0];
        REG_PRIME_X:   prime_x_r   <= cfg_data;
        REG_PRIME_Y:   prime_y_r   <= cfg_data;
        REG_PRIME_Z:   prime_z_r   <= cfg_data;
        default: ;  // drop writes to unknown indices
      endcase
    end
  end

  // Handshake and item capture
  state_t state_r, state_nxt;
  logic   init_done;
  logic   accept;

  assign busy   = (state_r != ST_IDLE) || !init_done;
  assign accept = start && !busy;

  logic signed [COORD_W-1:0] px_r, py_r, pz_r;
  logic [31:0] mag_x, mag_y, mag_z;

  // Magnitude of the most negative value wraps to 2^31, which is exact here.
  assign mag_x = in_pos_x[31] ? 32'(-in_pos_x) : in_pos_x;
  assign mag_y = in_pos_y[31] ? 32'(-in_pos_y) : in_pos_y;
  assign mag_z = in_pos_z[31] ? 32'(-in_pos_z) : in_pos_z;

  always_ff @(posedge clk) begin
    if (accept) begin
      px_r <= in_pos_x;
      py_r <= in_pos_y;
      pz_r <= in_pos_z;
    end
  end

  // Cell indices: three dividers run side by side and finish together.
  logic        dv_done_x, dv_done_y, dv_done_z;
  logic [31:0] ix, iy, iz;

  shvw_div u_div_x (
    .clk(clk), .rst_n(rst_n), .start(accept), .dividend(mag_x),
    .divisor(cell_size_r), .done(dv_done_x), .quotient(ix)
  );
  shvw_div u_div_y (
    .clk(clk), .rst_n(rst_n), .start(accept), .dividend(mag_y),
    .divisor(cell_size_r), .done(dv_done_y), .quotient(iy)
  );
  shvw_div u_div_z (
    .clk(clk), .rst_n(rst_n), .start(accept), .dividend(mag_z),
    .divisor(cell_size_r), .done(dv_done_z), .quotient(iz)
  );

  // Hash: register the three wrapped products, then the bucket.
  logic [31:0]         prod_x_r, prod_y_r, prod_z_r;
  logic [31:0]         hash_sum;
  logic [BUCKET_W-1:0] bucket_r;
  logic [FILL_W-1:0]   fill_r;
  logic [SLOT_W:0]     slot_r;

  assign hash_sum = prod_x_r + prod_y_r + prod_z_r;

  always_ff @(posedge clk) begin
    if (state_r == ST_MUL) begin
      prod_x_r <= 32'(ix * prime_x_r);
      prod_y_r <= 32'(iy * prime_y_r);
      prod_z_r <= 32'(iz * prime_z_r);
    end
    if (state_r == ST_SUM) begin
      bucket_r <= hash_sum[BUCKET_W-1:0];
    end
  end

  // Store
  mem_req_t             req;
  logic [3*COORD_W-1:0] pt_rdata;
  logic [FILL_W-1:0]    fill_rdata;

  shvw_store u_store (
    .clk(clk), .rst_n(rst_n), .req(req), .pt_rdata(pt_rdata),
    .fill_rdata(fill_rdata), .init_done(init_done)
  );

  // Tolerance window: |p - s| <= tol, formed at 33 bits so nothing wraps.
  logic signed [COORD_W:0] dx, dy, dz;
  logic [COORD_W:0]        ax, ay, az;
  logic                    hit;

  assign dx = 33'(px_r) - 33'($signed(pt_rdata[3*COORD_W-1:2*COORD_W]));
  assign dy = 33'(py_r) - 33'($signed(pt_rdata[2*COORD_W-1:COORD_W]));
  assign dz = 33'(pz_r) - 33'($signed(pt_rdata[COORD_W-1:0]));
  assign ax = dx[COORD_W] ? 33'(-dx) : dx;
  assign ay = dy[COORD_W] ? 33'(-dy) : dy;
  assign az = dz[COORD_W] ? 33'(-dz) : dz;
  assign hit = (ax <= 33'(tol_r)) && (ay <= 33'(tol_r)) && (az <= 33'(tol_r));

  logic last_slot;
  logic bucket_is_full;
  assign last_slot      = (slot_r + 1'b1) == (SLOT_W+1)'(fill_r);
  assign bucket_is_full = fill_r == FILL_MAX;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (accept) state_nxt = ST_DIV;
      ST_DIV:   if (dv_done_x && dv_done_y && dv_done_z) state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_SUM;
      ST_SUM:   state_nxt = ST_FRD;
      ST_FRD:   state_nxt = ST_FWAIT;
      ST_FWAIT: state_nxt = (fill_rdata == '0) ? ST_WR : ST_PRD;
      ST_PRD:   state_nxt = ST_CMP;
      ST_CMP: begin
        priority if (hit)       state_nxt = ST_IDLE;
        else if (last_slot)     state_nxt = ST_WR;
        else                    state_nxt = ST_PRD;
      end
      ST_WR:    state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  logic              fin;
  logic [ID_W-1:0]   fin_id;
  logic              fin_matched, fin_full;
  logic [ADDR_W-1:0] cur_addr;
  logic [ADDR_W-1:0] new_addr;

  assign cur_addr = {bucket_r, slot_r[SLOT_W-1:0]};
  assign new_addr = {bucket_r, fill_r[SLOT_W-1:0]};

  always_comb begin
    req            = '0;
    req.fill_addr  = bucket_r;
    req.pt_addr    = cur_addr;
    req.pt_wdata   = {px_r, py_r, pz_r};
    req.fill_wdata = fill_r + 1'b1;
    fin            = 1'b0;
    fin_id         = '0;
    fin_matched    = 1'b0;
    fin_full       = 1'b0;
    unique case (state_r)
      ST_CMP: begin
        if (hit) begin
          fin         = 1'b1;
          fin_id      = ID_W'(cur_addr);
          fin_matched = 1'b1;
        end
      end
      ST_WR: begin
        fin = 1'b1;
        if (bucket_is_full) begin
          fin_full = 1'b1;
        end else begin
          req.pt_addr = new_addr;
          req.pt_we   = 1'b1;
          req.fill_we = 1'b1;
          fin_id      = ID_W'(new_addr);
        end
      end
      default: ;
    endcase
  end

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_valid <= fin;
    end
    if (state_r == ST_FWAIT) begin
      // clamp a corrupt count to the bucket depth
      fill_r <= (fill_rdata > FILL_MAX) ? FILL_MAX : fill_rdata;
      slot_r <= '0;
    end else if (state_r == ST_CMP) begin
      slot_r <= slot_r + 1'b1;
    end
    if (fin) begin
      out_entry_id    <= fin_id;
      out_matched     <= fin_matched;
      out_bucket_full <= fin_full;
    end
  end

endmodule
